// File: hdl/pit_pkg.sv
package pit_pkg;

    // Default table size and fixed field widths.
    localparam int NUM_TASKS_DEF = 16;
    localparam int IDX_W         = 4;
    localparam int PRIO_W        = 8;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 16;

    // Operation codes.
    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_BLOCK   = 2'd1;
    localparam logic [1:0] OP_UNBLOCK = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CREATE,
        S_BK_LINK,
        S_BK_P,
        S_BK_RD,
        S_BK_EV,
        S_UB_RDW,
        S_UB_CHKW,
        S_UB_CHKO,
        S_UW_RD,
        S_UW_T,
        S_UW_SCAN,
        S_UW_DEC,
        S_UB_COMMIT,
        S_UB_ABORT,
        S_FIN_RD,
        S_FIN_OUT
    } t_state;

    // Write commands from the sequencer to the task table.
    typedef struct packed {
        logic create;    // base and effective priority set, link cleared
        logic eff_wr;    // effective priority written
        logic eff_tent;  // write goes to the tentative copy
        logic link_set;  // link set to the given target
        logic commit;    // tentative copy becomes current, link cleared
        logic abort;     // tentative copy dropped
    } t_tbl_cmd;

endpackage

// File: hdl/pit_table.sv
module pit_table
    import pit_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TW        = $clog2(NUM_TASKS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [TW-1:0]     i_waddr,
    input  logic [PRIO_W-1:0] i_wprio,
    input  logic [TW-1:0]     i_wtgt,
    input  logic [TW-1:0]     i_raddr,
    input  logic [TW-1:0]     i_chk_addr,
    output logic              o_chk_lv,
    output logic [TW-1:0]     o_rd_idx,
    output logic [PRIO_W-1:0] o_rd_base,
    output logic [PRIO_W-1:0] o_rd_eff,
    output logic [TW-1:0]     o_rd_tgt,
    output logic              o_rd_lv
);

    // Priority and link memories; effective priority is kept in two banks.
    logic [PRIO_W-1:0] base_mem [NUM_TASKS];
    logic [PRIO_W-1:0] eff0_mem [NUM_TASKS];
    logic [PRIO_W-1:0] eff1_mem [NUM_TASKS];
    logic [TW-1:0]     tgt_mem  [NUM_TASKS];

    // Per-entry flags: written bits, link bits, current bank and tentative marks.
    logic [NUM_TASKS-1:0] r_bv, r_ev0, r_ev1, r_lv, r_bank, r_dirty;
    logic [NUM_TASKS-1:0] n_bv, n_ev0, n_ev1, n_lv, n_bank, n_dirty;

    logic [TW-1:0]     r_ridx;
    logic [PRIO_W-1:0] r_rd_base, r_rd_eff0, r_rd_eff1;
    logic [TW-1:0]     r_rd_tgt;

    logic wr_eff;
    logic wr_sel;

    // Bank chosen for an effective priority write.
    assign wr_eff = i_cmd.create | i_cmd.eff_wr;
    assign wr_sel = r_bank[i_waddr] ^ (i_cmd.eff_wr & i_cmd.eff_tent);

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            base_mem[i_waddr] <= i_wprio;
        end
        if (wr_eff) begin
            if (wr_sel) begin
                eff1_mem[i_waddr] <= i_wprio;
            end else begin
                eff0_mem[i_waddr] <= i_wprio;
            end
        end
        if (i_cmd.link_set) begin
            tgt_mem[i_waddr] <= i_wtgt;
        end
    end

    // Registered reads at one address for all memories.
    always_ff @(posedge i_clk) begin
        r_ridx    <= i_raddr;
        r_rd_base <= base_mem[i_raddr];
        r_rd_eff0 <= eff0_mem[i_raddr];
        r_rd_eff1 <= eff1_mem[i_raddr];
        r_rd_tgt  <= tgt_mem[i_raddr];
    end

    // Next values of the per-entry flags.
    always_comb begin
        n_bv    = r_bv;
        n_ev0   = r_ev0;
        n_ev1   = r_ev1;
        n_lv    = r_lv;
        n_bank  = r_bank;
        n_dirty = r_dirty;
        if (i_cmd.create) begin
            n_bv[i_waddr] = 1'b1;
            n_lv[i_waddr] = 1'b0;
        end
        if (wr_eff) begin
            if (wr_sel) begin
                n_ev1[i_waddr] = 1'b1;
            end else begin
                n_ev0[i_waddr] = 1'b1;
            end
        end
        if (i_cmd.eff_wr && i_cmd.eff_tent) begin
            n_dirty[i_waddr] = 1'b1;
        end
        if (i_cmd.link_set) begin
            n_lv[i_waddr] = 1'b1;
        end
        if (i_cmd.commit) begin
            n_lv[i_waddr] = 1'b0;
            n_bank        = r_bank ^ r_dirty;
            n_dirty       = '0;
        end
        if (i_cmd.abort) begin
            n_dirty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv    <= '0;
            r_ev0   <= '0;
            r_ev1   <= '0;
            r_lv    <= '0;
            r_bank  <= '0;
            r_dirty <= '0;
        end else begin
            r_bv    <= n_bv;
            r_ev0   <= n_ev0;
            r_ev1   <= n_ev1;
            r_lv    <= n_lv;
            r_bank  <= n_bank;
            r_dirty <= n_dirty;
        end
    end

    // Read view: unwritten entries read as zero, tentative copy where marked.
    always_comb begin
        o_rd_idx  = r_ridx;
        o_rd_base = r_bv[r_ridx] ? r_rd_base : '0;
        if (r_bank[r_ridx] ^ r_dirty[r_ridx]) begin
            o_rd_eff = r_ev1[r_ridx] ? r_rd_eff1 : '0;
        end else begin
            o_rd_eff = r_ev0[r_ridx] ? r_rd_eff0 : '0;
        end
        o_rd_tgt  = r_rd_tgt;
        o_rd_lv   = r_lv[r_ridx];
        o_chk_lv  = r_lv[i_chk_addr];
    end

endmodule

// File: hdl/priority_inheritance_table.sv
// Flow from input transfer to result in the output register: read and create go straight
// to the result; a block visits up to NUM_TASKS chain entries, an unblock walks up to
// NUM_TASKS chain steps, as each step scans the table through the one read port.
// A block may be rejected before its walk, and an unblock refused before its walk.
// One item at a time: the next is taken once the result is stored.
// Reset is synchronous and active low; all tasks read as priority zero with no links at once.
module priority_inheritance_table
    import pit_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // opcode[1:0], owner_index[5:2], waiter_index[9:6], new_priority[17:10], zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // status[0], priority_out[8:1], zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int TW = $clog2(NUM_TASKS);

    t_state r_state, n_state;

    logic [1:0]        r_op, n_op;
    logic [TW-1:0]     r_own, n_own;
    logic [TW-1:0]     r_wt, n_wt;
    logic [PRIO_W-1:0] r_np, n_np;
    logic              r_own_ok, n_own_ok;
    logic              r_err, n_err;
    logic [TW-1:0]     r_t, n_t;
    logic [PRIO_W-1:0] r_p, n_p;
    logic [PRIO_W-1:0] r_eft, n_eft;
    logic [TW-1:0]     r_nxt, n_nxt;
    logic              r_nxt_lv, n_nxt_lv;
    logic [TW-1:0]     r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [PRIO_W-1:0] r_out_prio, n_out_prio;

    t_tbl_cmd          cmd;
    logic [TW-1:0]     waddr, wtgt, raddr, chk_addr;
    logic [PRIO_W-1:0] wprio;
    logic              chk_lv;
    logic [TW-1:0]     rd_idx, rd_tgt;
    logic [PRIO_W-1:0] rd_base, rd_eff;
    logic              rd_lv;

    logic [1:0]        in_op;
    logic [8:0]        own_ext, wt_ext;
    logic              own_ok, wt_ok, in_bad;
    logic              s_xfer, out_free;
    logic [PRIO_W-1:0] cmp_a, cmp_b;
    logic              cmp_gt, cmp_eq;
    logic              scan_hit, scan_last, step_last;

    // Input field decode and range checks.
    assign in_op    = i_s_axis_tdata[1:0];
    assign own_ext  = 9'(i_s_axis_tdata[5:2]);
    assign wt_ext   = 9'(i_s_axis_tdata[9:6]);
    assign own_ok   = own_ext < 9'(NUM_TASKS);
    assign wt_ok    = wt_ext < 9'(NUM_TASKS);
    assign in_bad   = !own_ok || (((in_op == OP_BLOCK) || (in_op == OP_UNBLOCK)) && !wt_ok);
    assign s_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    pit_table #(
        .NUM_TASKS (NUM_TASKS),
        .TW        (TW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_waddr    (waddr),
        .i_wprio    (wprio),
        .i_wtgt     (wtgt),
        .i_raddr    (raddr),
        .i_chk_addr (chk_addr),
        .o_chk_lv   (chk_lv),
        .o_rd_idx   (rd_idx),
        .o_rd_base  (rd_base),
        .o_rd_eff   (rd_eff),
        .o_rd_tgt   (rd_tgt),
        .o_rd_lv    (rd_lv)
    );

    // Shared priority comparator, operands chosen by the sequencer state.
    always_comb begin
        case (r_state)
            S_BK_EV: begin
                cmp_a = r_p;
                cmp_b = rd_eff;
            end
            S_UB_CHKO: begin
                cmp_a = r_p;
                cmp_b = rd_eff;
            end
            S_UW_SCAN: begin
                cmp_a = rd_eff;
                cmp_b = r_p;
            end
            default: begin
                cmp_a = r_p;
                cmp_b = r_eft;
            end
        endcase
    end

    assign cmp_gt    = cmp_a > cmp_b;
    assign cmp_eq    = cmp_a == cmp_b;
    assign scan_hit  = cmp_gt && rd_lv && (rd_tgt == r_t) && (rd_idx != r_wt);
    assign scan_last = rd_idx == TW'(NUM_TASKS - 1);
    assign step_last = r_step == TW'(NUM_TASKS - 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    if (in_bad) begin
                        n_state = S_FIN_RD;
                    end else begin
                        case (in_op)
                            OP_CREATE:  n_state = S_CREATE;
                            OP_BLOCK:   n_state = S_BK_LINK;
                            OP_UNBLOCK: n_state = S_UB_RDW;
                            default:    n_state = S_FIN_RD;
                        endcase
                    end
                end
            end
            S_CREATE:  n_state = S_FIN_RD;
            S_BK_LINK: n_state = chk_lv ? S_FIN_RD : S_BK_P;
            S_BK_P:    n_state = S_BK_RD;
            S_BK_RD:   n_state = S_BK_EV;
            S_BK_EV: begin
                if (!cmp_gt || !rd_lv || step_last) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_state = S_BK_RD;
                end
            end
            S_UB_RDW:  n_state = S_UB_CHKW;
            S_UB_CHKW: n_state = (!rd_lv || (rd_tgt != r_own)) ? S_FIN_RD : S_UB_CHKO;
            S_UB_CHKO: n_state = cmp_gt ? S_FIN_RD : S_UW_RD;
            S_UW_RD:   n_state = S_UW_T;
            S_UW_T:    n_state = S_UW_SCAN;
            S_UW_SCAN: n_state = scan_last ? S_UW_DEC : S_UW_SCAN;
            S_UW_DEC: begin
                if (cmp_gt) begin
                    n_state = S_UB_ABORT;
                end else if (cmp_eq || !r_nxt_lv || step_last) begin
                    n_state = S_UB_COMMIT;
                end else begin
                    n_state = S_UW_RD;
                end
            end
            S_UB_COMMIT: n_state = S_FIN_RD;
            S_UB_ABORT:  n_state = S_FIN_RD;
            S_FIN_RD:    n_state = S_FIN_OUT;
            S_FIN_OUT:   n_state = out_free ? S_IDLE : S_FIN_OUT;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs, table commands and datapath updates.
    always_comb begin
        o_s_axis_tready = 1'b0;
        cmd          = '0;
        waddr        = r_own;
        wprio        = r_np;
        wtgt         = r_own;
        raddr        = r_own;
        chk_addr     = r_wt;
        n_op         = r_op;
        n_own        = r_own;
        n_wt         = r_wt;
        n_np         = r_np;
        n_own_ok     = r_own_ok;
        n_err        = r_err;
        n_t          = r_t;
        n_p          = r_p;
        n_eft        = r_eft;
        n_nxt        = r_nxt;
        n_nxt_lv     = r_nxt_lv;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_prio   = r_out_prio;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (s_xfer) begin
                    n_op     = in_op;
                    n_own    = own_ext[TW-1:0];
                    n_wt     = wt_ext[TW-1:0];
                    n_np     = i_s_axis_tdata[17:10];
                    n_own_ok = own_ok;
                    n_err    = in_bad;
                end
            end
            S_CREATE: begin
                cmd.create = 1'b1;
            end
            S_BK_LINK: begin
                if (chk_lv) begin
                    n_err = 1'b1;
                end else begin
                    cmd.link_set = 1'b1;
                    waddr        = r_wt;
                    raddr        = r_wt;
                    n_t          = r_own;
                    n_step       = '0;
                end
            end
            S_BK_P: begin
                n_p = rd_eff;
            end
            S_BK_RD: begin
                raddr = r_t;
            end
            S_BK_EV: begin
                // Raise the owner and follow its link.
                if (cmp_gt) begin
                    cmd.eff_wr = 1'b1;
                    waddr      = r_t;
                    wprio      = r_p;
                    n_t        = rd_tgt;
                    n_step     = r_step + 1'b1;
                end
            end
            S_UB_RDW: begin
                raddr = r_wt;
            end
            S_UB_CHKW: begin
                if (!rd_lv || (rd_tgt != r_own)) begin
                    n_err = 1'b1;
                end else begin
                    n_p = rd_eff;
                end
            end
            S_UB_CHKO: begin
                if (cmp_gt) begin
                    n_err = 1'b1;
                end else begin
                    n_t    = r_own;
                    n_step = '0;
                end
            end
            S_UW_RD: begin
                raddr = r_t;
            end
            S_UW_T: begin
                n_p      = rd_base;
                n_eft    = rd_eff;
                n_nxt    = rd_tgt;
                n_nxt_lv = rd_lv;
                raddr    = '0;
            end
            S_UW_SCAN: begin
                // Take the highest priority among tasks still waiting on this one.
                if (scan_hit) begin
                    n_p = rd_eff;
                end
                raddr = rd_idx + 1'b1;
            end
            S_UW_DEC: begin
                if (cmp_gt) begin
                    n_err = 1'b1;
                end else if (!cmp_eq) begin
                    cmd.eff_wr   = 1'b1;
                    cmd.eff_tent = 1'b1;
                    waddr        = r_t;
                    wprio        = r_p;
                    n_t          = r_nxt;
                    n_step       = r_step + 1'b1;
                end
            end
            S_UB_COMMIT: begin
                cmd.commit = 1'b1;
                waddr      = r_wt;
            end
            S_UB_ABORT: begin
                cmd.abort = 1'b1;
            end
            S_FIN_RD: begin
                raddr = r_own;
            end
            S_FIN_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_err;
                    n_out_prio   = r_own_ok ? rd_eff : '0;
                end
            end
            default: begin
                n_err = r_err;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_step      <= n_step;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_own        <= n_own;
        r_wt         <= n_wt;
        r_np         <= n_np;
        r_own_ok     <= n_own_ok;
        r_t          <= n_t;
        r_p          <= n_p;
        r_eft        <= n_eft;
        r_nxt        <= n_nxt;
        r_nxt_lv     <= n_nxt_lv;
        r_out_status <= n_out_status;
        r_out_prio   <= n_out_prio;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_prio, r_out_status});

    // A transfer in starts an operation that holds off the next input.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !o_s_axis_tready)
        else $error("input taken while an operation is in progress");

    // A new result appears only from the final state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_FIN_OUT)
        else $error("result loaded outside the final state");

    // Chain walks never pass the step cap.
    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BK_EV) || (r_state == S_UW_DEC)) |-> r_step <= TW'(NUM_TASKS - 1))
        else $error("chain walk beyond the step cap");

    // A successful unblock is never committed with the error flag set.
    a_commit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UB_COMMIT) |-> (!r_err && (r_op == OP_UNBLOCK)))
        else $error("commit of a rejected or foreign operation");

endmodule

// File: tb/pit_prio_tracker.sv
module pit_prio_tracker
    import pit_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // opcode[1:0], owner_index[5:2], waiter_index[9:6], new_priority[17:10], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // status[0], priority_out[8:1], zero pad
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_rejected
);

    localparam int   TASKS         = NUM_TASKS_DEF;
    localparam int   REPORT_LIMIT  = 10;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct {
        logic              status;
        logic [PRIO_W-1:0] prio;
    } t_outcome;

    // Our own copy of the task table.
    logic [PRIO_W-1:0] eff_prio  [TASKS];
    logic [PRIO_W-1:0] base_prio [TASKS];
    logic              linked    [TASKS];
    logic [IDX_W-1:0]  blocker   [TASKS];

    t_outcome outcome_q[$];
    int       mismatches;
    int       reports;
    int       checked;
    int       rejected;

    // Link a waiter to an owner and push its priority up the chain of owners.
    function automatic logic link_waiter(int own, int wt);
        int                t;
        int                step;
        logic [PRIO_W-1:0] p;
        if (linked[wt])
            return 1'b0;
        linked[wt]  = 1'b1;
        blocker[wt] = own[IDX_W-1:0];
        p = eff_prio[wt];
        t = own;
        for (step = 0; step < TASKS; step++) begin
            if (!(p > eff_prio[t]))
                break;
            eff_prio[t] = p;
            if (!linked[t])
                break;
            t = int'(blocker[t]);
        end
        return 1'b1;
    endfunction

    // Drop a link, then lower owners down the chain on a scratch copy. The whole
    // operation is rejected if any owner would have to rise.
    function automatic logic unlink_waiter(int own, int wt);
        logic [PRIO_W-1:0] scratch [TASKS];
        logic [PRIO_W-1:0] p;
        int                t;
        int                step;
        int                j;
        if (!linked[wt] || blocker[wt] != own[IDX_W-1:0])
            return 1'b0;
        if (eff_prio[own] < eff_prio[wt])
            return 1'b0;
        scratch = eff_prio;
        t = own;
        for (step = 0; step < TASKS; step++) begin
            p = base_prio[t];
            for (j = 0; j < TASKS; j++) begin
                if (j != wt && linked[j] && blocker[j] == t[IDX_W-1:0] && scratch[j] > p)
                    p = scratch[j];
            end
            if (p > scratch[t])
                return 1'b0;
            if (p == scratch[t])
                break;
            scratch[t] = p;
            if (!linked[t])
                break;
            t = int'(blocker[t]);
        end
        linked[wt] = 1'b0;
        eff_prio = scratch;
        return 1'b1;
    endfunction

    // Apply one operation to the table and return the result it must produce.
    // With a table of 16 tasks every 4-bit index is in range.
    function automatic t_outcome apply_op(logic [S_TDATA_W-1:0] word);
        logic [1:0]        op;
        int                own;
        int                wt;
        logic [PRIO_W-1:0] np;
        logic              ok;
        t_outcome          res;
        op  = word[1:0];
        own = int'(word[5:2]);
        wt  = int'(word[9:6]);
        np  = word[17:10];
        case (op)
            OP_CREATE: begin
                base_prio[own] = np;
                eff_prio[own]  = np;
                linked[own]    = 1'b0;
                ok = 1'b1;
            end
            OP_BLOCK: begin
                ok = link_waiter(own, wt);
            end
            OP_UNBLOCK: begin
                ok = unlink_waiter(own, wt);
            end
            default: begin
                ok = 1'b1;
            end
        endcase
        res.status = ok ? STATUS_OK : STATUS_REJECT;
        res.prio   = eff_prio[own];
        return res;
    endfunction

    // Watch both channels; results are checked before the new transfer is predicted.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int k = 0; k < TASKS; k++) begin
                eff_prio[k]  = '0;
                base_prio[k] = '0;
                linked[k]    = 1'b0;
                blocker[k]   = '0;
            end
            outcome_q.delete();
            mismatches = 0;
            reports    = 0;
            checked    = 0;
            rejected   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                if (i_m_tdata[0] == STATUS_REJECT)
                    rejected++;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (reports < REPORT_LIMIT) begin
                        reports++;
                        $display("[%0t] unexpected result: status=%0d prio=%0d", $realtime,
                                 i_m_tdata[0], i_m_tdata[8:1]);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (i_m_tdata[0] !== want.status || i_m_tdata[8:1] !== want.prio) begin
                        mismatches++;
                        if (reports < REPORT_LIMIT) begin
                            reports++;
                            $display("[%0t] result %0d: status exp=%0d got=%0d, prio exp=%0d got=%0d",
                                     $realtime, checked, want.status, i_m_tdata[0],
                                     want.prio, i_m_tdata[8:1]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(apply_op(i_s_tdata));
        end
        o_fail_count <= mismatches;
        o_pending    <= outcome_q.size();
        o_checked    <= checked;
        o_rejected   <= rejected;
    end

endmodule

// File: tb/tb.sv
module tb;
    import pit_pkg::*;

    localparam int LIMIT        = 3_000_000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 400;
    localparam int IDLE_PCT     = 16;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int rejected;

    // Stimulus side controls shared with the result drain.
    logic calm = 1'b0;
    int   hold_requests = 0;
    int   items_sent = 0;

    // Best guess of the links, used only to steer the random operations.
    logic             guess_linked [NUM_TASKS_DEF];
    logic [IDX_W-1:0] guess_owner  [NUM_TASKS_DEF];

    always #10 clk = ~clk;

    priority_inheritance_table #(
        .NUM_TASKS(NUM_TASKS_DEF)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pit_prio_tracker prio_track (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rejected   (rejected)
    );

    // Offer one operation and wait for its transfer. Called at a falling edge.
    task automatic send_op(input logic [1:0] op, input logic [IDX_W-1:0] own,
                           input logic [IDX_W-1:0] wt, input logic [PRIO_W-1:0] np);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tdata  = {{(S_TDATA_W - 18){1'b0}}, np, wt, own, op};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
        case (op)
            OP_CREATE: begin
                guess_linked[own] = 1'b0;
            end
            OP_BLOCK: begin
                if (!guess_linked[wt]) begin
                    guess_linked[wt] = 1'b1;
                    guess_owner[wt]  = own;
                end
            end
            OP_UNBLOCK: begin
                if (guess_linked[wt] && guess_owner[wt] == own)
                    guess_linked[wt] = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // Priorities lean toward the extremes now and then.
    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return PRIO_W'($urandom_range(255));
    endfunction

    // Find a task in 0..pool whose guessed link state matches, or -1.
    function automatic int find_task(logic want_linked, int pool);
        int start;
        int idx;
        start = $urandom_range(pool);
        for (int k = 0; k <= pool; k++) begin
            idx = (start + k) % (pool + 1);
            if (guess_linked[idx] == want_linked)
                return idx;
        end
        return -1;
    endfunction

    // Result drain: random stalls, quiet while calm, and long hold-offs on request.
    initial begin : drain
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Cycle counter that ends a hung run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int r;
        int pool;
        int own;
        int wt;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int k = 0; k < NUM_TASKS_DEF; k++) begin
            guess_linked[k] = 1'b0;
            guess_owner[k]  = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Extremes of the priority range.
        send_op(OP_CREATE, 0, 15, 8'd0);
        send_op(OP_CREATE, 15, 0, 8'd255);
        send_op(OP_READ, 15, 15, 8'd255);

        // A two-step chain: 15 waits on 1, 1 waits on 2. Then a block of a linked waiter,
        // an unblock naming the wrong owner, and a good unblock that lowers both owners.
        send_op(OP_CREATE, 1, 0, 8'd10);
        send_op(OP_CREATE, 2, 0, 8'd20);
        send_op(OP_BLOCK, 1, 15, 8'd0);
        send_op(OP_BLOCK, 2, 1, 8'd0);
        send_op(OP_BLOCK, 0, 15, 8'd0);
        send_op(OP_UNBLOCK, 3, 15, 8'd0);
        send_op(OP_UNBLOCK, 1, 15, 8'd0);

        // Recreating an owner keeps its waiter's link, so the waiter is now more
        // urgent than the owner and the unblock is refused.
        send_op(OP_CREATE, 4, 0, 8'd5);
        send_op(OP_CREATE, 5, 0, 8'd1);
        send_op(OP_BLOCK, 5, 4, 8'd0);
        send_op(OP_CREATE, 5, 0, 8'd1);
        send_op(OP_UNBLOCK, 5, 4, 8'd0);

        // An owner lowered under another waiter: the unblock walk would raise it.
        send_op(OP_CREATE, 6, 0, 8'd50);
        send_op(OP_CREATE, 7, 0, 8'd40);
        send_op(OP_CREATE, 8, 0, 8'd30);
        send_op(OP_BLOCK, 6, 7, 8'd0);
        send_op(OP_BLOCK, 6, 8, 8'd0);
        send_op(OP_CREATE, 6, 0, 8'd35);
        send_op(OP_UNBLOCK, 6, 8, 8'd0);

        // A task blocked on itself, then a two-task cycle raised from outside.
        send_op(OP_BLOCK, 9, 9, 8'd0);
        send_op(OP_UNBLOCK, 9, 9, 8'd0);
        send_op(OP_BLOCK, 12, 13, 8'd0);
        send_op(OP_BLOCK, 13, 12, 8'd0);
        send_op(OP_BLOCK, 12, 15, 8'd0);

        // Random traffic, mostly well-formed block and unblock pairs. The first half
        // uses eight tasks so chains grow deep; a middle stretch has no idling.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 700 && i < 1100);
            if (i == 300 || i == 1500)
                hold_requests++;
            pool = (i < RANDOM_ITEMS / 2) ? 7 : NUM_TASKS_DEF - 1;
            r = $urandom_range(99);
            if (r < 8) begin
                send_op(2'($urandom_range(3)), IDX_W'($urandom_range(15)),
                        IDX_W'($urandom_range(15)), PRIO_W'($urandom_range(255)));
            end else if (r < 30) begin
                send_op(OP_CREATE, IDX_W'($urandom_range(pool)), IDX_W'($urandom_range(15)),
                        pick_prio());
            end else if (r < 60) begin
                wt = find_task(1'b0, pool);
                if (wt < 0 || $urandom_range(99) < 10)
                    wt = int'($urandom_range(pool));
                send_op(OP_BLOCK, IDX_W'($urandom_range(pool)), IDX_W'(wt),
                        PRIO_W'($urandom_range(255)));
            end else if (r < 85) begin
                wt  = find_task(1'b1, pool);
                own = (wt >= 0) ? int'(guess_owner[wt]) : int'($urandom_range(pool));
                if (wt < 0 || $urandom_range(99) < 15) begin
                    wt  = int'($urandom_range(pool));
                    own = int'($urandom_range(pool));
                end
                send_op(OP_UNBLOCK, IDX_W'(own), IDX_W'(wt), PRIO_W'($urandom_range(255)));
            end else begin
                send_op(OP_READ, IDX_W'($urandom_range(pool)), IDX_W'($urandom_range(15)),
                        PRIO_W'($urandom_range(255)));
            end
        end
        calm = 1'b0;
        s_tvalid = 1'b0;

        // Drain every outstanding result, then give the block time to misbehave.
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d operations: directed corner cases, then random create, block,",
                 items_sent);
        $display("unblock and read traffic with stalls; %0d results checked, %0d rejected.",
                 checked, rejected);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
